@@ rtl/alte_pkg.sv @@
// ----------------------------------------------------------------------------
// Array list table engine package
// Shared constants, command codes and controller/datapath types.
// ----------------------------------------------------------------------------
package alte_pkg;

   localparam int LIST_DEPTH = 1024;

   localparam int OP_W   = 4;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 32;
   localparam int ST_W   = 3;
   localparam int FIDX_W = 10;
   localparam int CNT_W  = 11;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_INS_END   = 4'd1;
   localparam logic [OP_W-1:0] OP_INS_IDX   = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_END   = 4'd4;
   localparam logic [OP_W-1:0] OP_DEL_IDX   = 4'd5;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd6;
   localparam logic [OP_W-1:0] OP_LIN_SRCH  = 4'd7;
   localparam logic [OP_W-1:0] OP_BIN_SRCH  = 4'd8;
   localparam logic [OP_W-1:0] OP_CHECK     = 4'd9;
   localparam logic [OP_W-1:0] OP_SORT      = 4'd10;
   localparam logic [OP_W-1:0] OP_READ      = 4'd11;

   localparam logic [ST_W-1:0] ST_OK         = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY      = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_INDEX  = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_SORTED = 3'd4;
   localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd5;
   localparam logic [ST_W-1:0] ST_SORTED     = 3'd6;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_ZERO, PTR_LAST, PTR_POS_P1, PTR_INC, PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {RA_PTR, RA_MID, RA_POS} ra_sel_type;
   typedef enum logic [1:0] {WA_UP, WA_DOWN, WA_POS, WA_D1} wa_sel_type;
   typedef enum logic [1:0] {WD_VAL, WD_RDATA, WD_CARRY, WD_MIN} wd_sel_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLEAR} cnt_op_type;
   typedef enum logic [1:0] {SRT_HOLD, SRT_SET, SRT_SCAN} srt_op_type;

   typedef struct packed {
      logic            latch;
      ptr_op_type      ptr_op;
      logic            rd_en;
      ra_sel_type      ra_sel;
      logic            wr_en;
      wa_sel_type      wa_sel;
      wd_sel_type      wd_sel;
      cnt_op_type      cnt_op;
      logic            bs_init;
      logic            bs_step;
      logic            swap_clr;
      logic            scan_step;
      logic            bub_step;
      srt_op_type      srt_op;
      logic            set_status;
      logic [ST_W-1:0] status;
      logic            found_load;
      logic            rdv_load;
      logic            out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rv;
      logic            cnt_zero;
      logic            cnt_le1;
      logic            cnt_full;
      logic            pos_gt_cnt;
      logic            pos_ge_cnt;
      logic            pos_eq_cnt;
      logic            pos_eq_last;
      logic            ptr_eq_pos;
      logic            ptr_eq_last;
      logic            ptr_lt_cnt;
      logic            d1_zero;
      logic            d1_eq_last;
      logic            rd_eq_key;
      logic            bs_done;
      logic            sorted;
      logic            swap;
      logic            out_busy;
   } dp_sts_type;

endpackage

@@ rtl/alte_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one list command.
// ----------------------------------------------------------------------------
interface alte_req_if;
   logic                         valid;
   logic                         ready;
   logic [alte_pkg::OP_W-1:0]    opcode;
   logic [alte_pkg::POS_W-1:0]   position;
   logic signed [alte_pkg::VAL_W-1:0] new_value;
   logic signed [alte_pkg::VAL_W-1:0] search_key;

   modport source (output valid, opcode, position, new_value, search_key, input ready);
   modport sink   (input valid, opcode, position, new_value, search_key, output ready);
endinterface

@@ rtl/alte_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface alte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [alte_pkg::ST_W-1:0]     status;
   logic [alte_pkg::FIDX_W-1:0]   found_index;
   logic signed [alte_pkg::VAL_W-1:0] read_value;
   logic                          is_sorted;
   logic [alte_pkg::CNT_W-1:0]    entry_count;

   modport source (output valid, status, found_index, read_value, is_sorted, entry_count,
                   input ready);
   modport sink   (input valid, status, found_index, read_value, is_sorted, entry_count,
                   output ready);
endinterface

@@ rtl/array_list_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// Array list table engine
// Packed list of signed words with insert, delete, search, sort and read.
//
//   Channel  Direction  Transaction
//   req_     in         opcode, position, new_value, search_key
//   rsp_     out        status, found_index, read_value, is_sorted, entry_count
//
// One command at a time; every command gives one result transaction.
// Checks, clear and read run without walking the store; shifts and linear
// searches walk the store at one entry a cycle; binary search reads, then
// compares, each probe; sort runs bubble passes until one makes no swap.
// Every insert and delete ends with a sortedness scan unless at most one
// entry remains, and clear marks the list sorted; walks are paced by the
// single read port of the list store.
// Reset clears the count, read-valid and result valid and marks the list sorted; the store needs no clearing pass.
// A waiting result does not stop the next command from being taken.
// ----------------------------------------------------------------------------
module array_list_table_engine_top #(
   parameter int DEPTH = alte_pkg::LIST_DEPTH
) (
   input logic       clock,
   input logic       reset,
   alte_req_if.sink  req_chan,
   alte_rsp_if.source rsp_chan
);
   import alte_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   alte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   alte_dp #(.DEPTH(DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_chan.opcode),
      .req_position    (req_chan.position),
      .req_new_value   (req_chan.new_value),
      .req_search_key  (req_chan.search_key),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_found_index (rsp_chan.found_index),
      .rsp_read_value  (rsp_chan.read_value),
      .rsp_is_sorted   (rsp_chan.is_sorted),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

@@ rtl/alte_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/alte_ctrl.sv @@
// ----------------------------------------------------------------------------
// Array list table engine controller
// Sequences each command as a walk over the list store.
// ----------------------------------------------------------------------------
module alte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  alte_pkg::dp_sts_type  sts,
   output alte_pkg::dp_cmd_type  cmd
);
   import alte_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_UP_RD, S_UP_FLUSH, S_PUT, S_DN_RD, S_DN_FLUSH,
      S_SCAN_INIT, S_SCAN, S_SCAN_END, S_LIN_RD, S_BIN_RD, S_BIN_CMP,
      S_SORT_INIT, S_SORT_RD, S_SORT_FLUSH, S_READ_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.ptr_op = PTR_HOLD;
      cmd.ra_sel = RA_PTR;
      cmd.wa_sel = WA_UP;
      cmd.wd_sel = WD_RDATA;
      cmd.cnt_op = CNT_HOLD;
      cmd.srt_op = SRT_HOLD;
      cmd.status = ST_OK;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (sts.op)
               OP_INS_FRONT, OP_INS_END, OP_INS_IDX: begin
                  if (sts.cnt_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else if (sts.pos_gt_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                  end else if (sts.pos_eq_cnt) begin
                     state_in = S_PUT;
                  end else begin
                     cmd.ptr_op = PTR_LAST;
                     state_in   = S_UP_RD;
                  end
               end
               OP_DEL_FRONT, OP_DEL_IDX: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (sts.pos_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                  end else if (sts.pos_eq_last) begin
                     cmd.cnt_op = CNT_DEC;
                     state_in   = S_SCAN_INIT;
                  end else begin
                     cmd.ptr_op = PTR_POS_P1;
                     state_in   = S_DN_RD;
                  end
               end
               OP_DEL_END: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.cnt_op = CNT_DEC;
                     state_in   = S_SCAN_INIT;
                  end
               end
               OP_CLEAR: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.cnt_op = CNT_CLEAR;
                     cmd.srt_op = SRT_SET;
                  end
               end
               OP_LIN_SRCH: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_LIN_RD;
                  end
               end
               OP_BIN_SRCH: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (!sts.sorted) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NOT_SORTED;
                  end else begin
                     cmd.bs_init = 1'b1;
                     state_in    = S_BIN_RD;
                  end
               end
               OP_SORT: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (sts.sorted) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_SORTED;
                  end else begin
                     state_in = S_SORT_INIT;
                  end
               end
               OP_READ: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (sts.pos_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_INDEX;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.ra_sel = RA_POS;
                     state_in   = S_READ_WAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_UP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = sts.rv;
            cmd.wa_sel = WA_UP;
            if (sts.ptr_eq_pos) begin
               state_in = S_UP_FLUSH;
            end else begin
               cmd.ptr_op = PTR_DEC;
            end
         end
         S_UP_FLUSH: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_UP;
            state_in   = S_PUT;
         end
         S_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.wd_sel = WD_VAL;
            cmd.cnt_op = CNT_INC;
            state_in   = S_SCAN_INIT;
         end
         S_DN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = sts.rv;
            cmd.wa_sel = WA_DOWN;
            if (sts.ptr_eq_last) begin
               state_in = S_DN_FLUSH;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_DN_FLUSH: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_DOWN;
            cmd.cnt_op = CNT_DEC;
            state_in   = S_SCAN_INIT;
         end
         S_SCAN_INIT: begin
            cmd.ptr_op   = PTR_ZERO;
            cmd.swap_clr = 1'b1;
            if (sts.cnt_le1) begin
               cmd.srt_op = SRT_SET;
               state_in   = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en     = sts.ptr_lt_cnt;
            cmd.ptr_op    = sts.ptr_lt_cnt ? PTR_INC : PTR_HOLD;
            cmd.scan_step = 1'b1;
            if (sts.rv && sts.d1_eq_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            cmd.srt_op = SRT_SCAN;
            state_in   = S_DONE;
         end
         S_LIN_RD: begin
            cmd.rd_en  = sts.ptr_lt_cnt;
            cmd.ptr_op = sts.ptr_lt_cnt ? PTR_INC : PTR_HOLD;
            if (sts.rv && sts.rd_eq_key) begin
               cmd.found_load = 1'b1;
               state_in       = S_DONE;
            end else if (sts.rv && sts.d1_eq_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_BIN_RD: begin
            if (sts.bs_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.ra_sel = RA_MID;
               state_in   = S_BIN_CMP;
            end
         end
         S_BIN_CMP: begin
            if (sts.rd_eq_key) begin
               cmd.found_load = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.bs_step = 1'b1;
               state_in    = S_BIN_RD;
            end
         end
         S_SORT_INIT: begin
            cmd.ptr_op   = PTR_ZERO;
            cmd.swap_clr = 1'b1;
            state_in     = S_SORT_RD;
         end
         S_SORT_RD: begin
            cmd.rd_en    = sts.ptr_lt_cnt;
            cmd.ptr_op   = sts.ptr_lt_cnt ? PTR_INC : PTR_HOLD;
            cmd.bub_step = 1'b1;
            cmd.wr_en    = sts.rv && !sts.d1_zero;
            cmd.wa_sel   = WA_DOWN;
            cmd.wd_sel   = WD_MIN;
            if (sts.rv && sts.d1_eq_last) begin
               state_in = S_SORT_FLUSH;
            end
         end
         S_SORT_FLUSH: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_D1;
            cmd.wd_sel = WD_CARRY;
            if (sts.swap) begin
               state_in = S_SORT_INIT;
            end else begin
               cmd.srt_op = SRT_SET;
               state_in   = S_DONE;
            end
         end
         S_READ_WAIT: begin
            cmd.rdv_load = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/alte_dp.sv @@
// ----------------------------------------------------------------------------
// Array list table engine datapath
// List store, count, walk pointers, comparators and result register.
// ----------------------------------------------------------------------------
module alte_dp #(
   parameter int DEPTH = alte_pkg::LIST_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  alte_pkg::dp_cmd_type              cmd,
   output alte_pkg::dp_sts_type              sts,
   input  logic [alte_pkg::OP_W-1:0]         req_opcode,
   input  logic [alte_pkg::POS_W-1:0]        req_position,
   input  logic signed [alte_pkg::VAL_W-1:0] req_new_value,
   input  logic signed [alte_pkg::VAL_W-1:0] req_search_key,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [alte_pkg::ST_W-1:0]         rsp_status,
   output logic [alte_pkg::FIDX_W-1:0]       rsp_found_index,
   output logic signed [alte_pkg::VAL_W-1:0] rsp_read_value,
   output logic                              rsp_is_sorted,
   output logic [alte_pkg::CNT_W-1:0]        rsp_entry_count
);
   import alte_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > POS_W) ? CW : POS_W;

   logic [OP_W-1:0]  op_ff;
   logic [LW-1:0]    pos_ff;
   logic [VAL_W-1:0] val_ff, key_ff, carry_ff, rdv_ff;
   logic [CW-1:0]    cnt_ff, cnt_in, ptr_ff, ptr_in, lo_ff, hi_ff;
   logic [AW-1:0]    d1_ff, found_ff;
   logic             rv_ff, swap_ff, sorted_ff;
   logic [ST_W-1:0]  status_ff;

   logic             out_valid_ff, out_sorted_ff;
   logic [ST_W-1:0]  out_status_ff;
   logic [FIDX_W-1:0] out_found_ff;
   logic [VAL_W-1:0] out_rdv_ff;
   logic [CNT_W-1:0] out_cnt_ff;

   logic [AW-1:0]    rd_addr, wr_addr;
   logic [VAL_W-1:0] wr_data, rd_data;
   logic [CW:0]      mid_sum;
   logic [CW-1:0]    mid;
   logic [LW-1:0]    cnt_x, pos_eff;
   logic             gt;
   logic [31:0]      found_x, cnt_w;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign mid     = mid_sum[CW:1];
   assign cnt_x   = LW'(cnt_ff);
   assign gt      = $signed(carry_ff) > $signed(rd_data);

   always_comb begin
      case (req_opcode)
         OP_INS_FRONT, OP_DEL_FRONT: pos_eff = '0;
         OP_INS_END:                 pos_eff = cnt_x;
         default:                    pos_eff = LW'(req_position);
      endcase
   end

   always_comb begin
      case (cmd.ra_sel)
         RA_MID:  rd_addr = mid[AW-1:0];
         RA_POS:  rd_addr = pos_ff[AW-1:0];
         default: rd_addr = ptr_ff[AW-1:0];
      endcase
      case (cmd.wa_sel)
         WA_UP:   wr_addr = d1_ff + AW'(1);
         WA_DOWN: wr_addr = d1_ff - AW'(1);
         WA_POS:  wr_addr = pos_ff[AW-1:0];
         default: wr_addr = d1_ff;
      endcase
      case (cmd.wd_sel)
         WD_VAL:   wr_data = val_ff;
         WD_CARRY: wr_data = carry_ff;
         WD_MIN:   wr_data = gt ? rd_data : carry_ff;
         default:  wr_data = rd_data;
      endcase
      case (cmd.ptr_op)
         PTR_ZERO:   ptr_in = '0;
         PTR_LAST:   ptr_in = cnt_ff - CW'(1);
         PTR_POS_P1: ptr_in = CW'(pos_ff) + CW'(1);
         PTR_INC:    ptr_in = ptr_ff + CW'(1);
         PTR_DEC:    ptr_in = ptr_ff - CW'(1);
         default:    ptr_in = ptr_ff;
      endcase
      case (cmd.cnt_op)
         CNT_INC:   cnt_in = cnt_ff + CW'(1);
         CNT_DEC:   cnt_in = cnt_ff - CW'(1);
         CNT_CLEAR: cnt_in = '0;
         default:   cnt_in = cnt_ff;
      endcase
   end

   alte_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         sorted_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rv_ff  <= cmd.rd_en;
         case (cmd.srt_op)
            SRT_SET:  sorted_ff <= 1'b1;
            SRT_SCAN: sorted_ff <= !swap_ff;
            default:  sorted_ff <= sorted_ff;
         endcase
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.rd_en) begin
         d1_ff <= rd_addr;
      end
      if (cmd.latch) begin
         op_ff     <= req_opcode;
         pos_ff    <= pos_eff;
         val_ff    <= req_new_value;
         key_ff    <= req_search_key;
         status_ff <= ST_OK;
         found_ff  <= '0;
         rdv_ff    <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.found_load) begin
            found_ff <= d1_ff;
         end
         if (cmd.rdv_load) begin
            rdv_ff <= rd_data;
         end
      end
      if (cmd.bs_init) begin
         lo_ff <= '0;
         hi_ff <= cnt_ff;
      end else if (cmd.bs_step) begin
         if ($signed(rd_data) > $signed(key_ff)) begin
            hi_ff <= CW'(d1_ff);
         end else begin
            lo_ff <= CW'(d1_ff) + CW'(1);
         end
      end
      if (cmd.swap_clr) begin
         swap_ff <= 1'b0;
      end else if (cmd.scan_step && rv_ff) begin
         if (d1_ff != '0 && gt) begin
            swap_ff <= 1'b1;
         end
         carry_ff <= rd_data;
      end else if (cmd.bub_step && rv_ff) begin
         if (d1_ff == '0 || !gt) begin
            carry_ff <= rd_data;
         end else begin
            swap_ff <= 1'b1;
         end
      end
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_found_ff  <= found_x[FIDX_W-1:0];
         out_rdv_ff    <= rdv_ff;
         out_sorted_ff <= sorted_ff;
         out_cnt_ff    <= cnt_w[CNT_W-1:0];
      end
   end

   assign found_x = 32'(found_ff);
   assign cnt_w   = 32'(cnt_ff);

   always_comb begin
      sts.op          = op_ff;
      sts.rv          = rv_ff;
      sts.cnt_zero    = (cnt_ff == '0);
      sts.cnt_le1     = (cnt_ff <= CW'(1));
      sts.cnt_full    = (cnt_ff == CW'(DEPTH));
      sts.pos_gt_cnt  = (pos_ff > cnt_x);
      sts.pos_ge_cnt  = (pos_ff >= cnt_x);
      sts.pos_eq_cnt  = (pos_ff == cnt_x);
      sts.pos_eq_last = ((pos_ff + LW'(1)) == cnt_x);
      sts.ptr_eq_pos  = (LW'(ptr_ff) == pos_ff);
      sts.ptr_eq_last = ((ptr_ff + CW'(1)) == cnt_ff);
      sts.ptr_lt_cnt  = (ptr_ff < cnt_ff);
      sts.d1_zero     = (d1_ff == '0);
      sts.d1_eq_last  = ((CW'(d1_ff) + CW'(1)) == cnt_ff);
      sts.rd_eq_key   = (rd_data == key_ff);
      sts.bs_done     = (lo_ff >= hi_ff);
      sts.sorted      = sorted_ff;
      sts.swap        = swap_ff;
      sts.out_busy    = out_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_index = out_found_ff;
   assign rsp_read_value  = out_rdv_ff;
   assign rsp_is_sorted   = out_sorted_ff;
   assign rsp_entry_count = out_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("Entry count exceeds the list depth.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(out_valid_ff && !rsp_ready))
      else $error("Result loaded over a waiting transaction.");

   a_bin_sorted: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.ra_sel == RA_MID) |-> sorted_ff)
      else $error("Binary search probe on an unsorted list.");

endmodule
